@@ src/b64enc_pkg.sv @@
// ============================================================================
// b64enc_pkg: shared types and functions for the base64 stream encoder
// Group descriptor passed from the byte gatherer to the character emitter,
// queue sizing and the standard base64 alphabet lookup.
// ============================================================================
`default_nettype none

package b64enc_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [6:0] PAD_CHAR = 7'h3D;  // '='

  // One group of up to three bytes, ready for encoding
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [2:0] nchars;  // alphabet characters before padding: 2, 3 or 4
    logic       last;    // group ends the message
  } group_t;

  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    logic [6:0] c;
    if (v < 6'd26) begin
      c = 7'h41 + {1'b0, v};
    end else if (v < 6'd52) begin
      c = 7'h61 + {1'b0, v} - 7'd26;
    end else if (v < 6'd62) begin
      c = 7'h30 + {1'b0, v} - 7'd52;
    end else if (v == 6'd62) begin
      c = 7'h2B;  // '+'
    end else begin
      c = 7'h2F;  // '/'
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ src/b64enc_if.sv @@
// ============================================================================
// b64enc_if: valid/ready channel interfaces of the base64 stream encoder
// Byte input channel and character output channel, each with a source and
// a sink modport.
// ============================================================================
`default_nettype none

interface b64enc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface b64enc_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       out_last;

  modport source (output valid, output out_char, output out_last, input ready);
  modport sink   (input valid, input out_char, input out_last, output ready);
endinterface

`default_nettype wire

@@ src/b64enc_front.sv @@
// ============================================================================
// b64enc_front: byte gatherer
// Collects bytes into groups of three, closes a partial group on the last
// byte and pushes each finished group into the queue.
// ============================================================================
`default_nettype none

module b64enc_front
  import b64enc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  b64enc_in_if.sink   bytes,
  input  wire logic   queue_full,
  output logic        push,
  output group_t      push_group
);

  logic [7:0] held [2];
  logic [1:0] held_count;
  logic       accept;
  logic       group_full;

  assign bytes.ready = !queue_full;
  assign accept      = bytes.valid && bytes.ready;
  // a count of three behaves as two
  assign group_full  = held_count[1];
  assign push        = accept && (group_full || bytes.in_last);

  always_comb begin
    push_group.last = bytes.in_last;
    if (group_full) begin
      push_group.b0     = held[0];
      push_group.b1     = held[1];
      push_group.b2     = bytes.in_byte;
      push_group.nchars = 3'd4;
    end else if (held_count[0]) begin
      push_group.b0     = held[0];
      push_group.b1     = bytes.in_byte;
      push_group.b2     = 8'h00;
      push_group.nchars = 3'd3;
    end else begin
      push_group.b0     = bytes.in_byte;
      push_group.b1     = 8'h00;
      push_group.b2     = 8'h00;
      push_group.nchars = 3'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
    end else if (accept) begin
      if (push) begin
        held_count <= 2'd0;
      end else begin
        held_count <= held_count + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !group_full) begin
      held[held_count[0]] <= bytes.in_byte;
    end
  end

endmodule

`default_nettype wire

@@ src/b64enc_queue.sv @@
// ============================================================================
// b64enc_queue: group queue
// Short FIFO of group descriptors between the gatherer and the emitter.
// ============================================================================
`default_nettype none

module b64enc_queue
  import b64enc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire group_t push_group,
  output logic        full,
  output logic        head_valid,
  output group_t      head_group,
  input  wire logic   pop
);

  group_t                 entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_push;
  logic                   do_pop;

  assign full       = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_group = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
    logic [QUEUE_PTR_W-1:0] n;
    if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + QUEUE_PTR_W'(1);
    end
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QUEUE_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_group;
    end
  end

endmodule

`default_nettype wire

@@ src/b64enc_back.sv @@
// ============================================================================
// b64enc_back: character emitter
// Takes one group at a time from the queue and sends its four characters,
// alphabet or pad, through a registered output stage.
// ============================================================================
`default_nettype none

module b64enc_back
  import b64enc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    head_valid,
  input  wire group_t  head_group,
  output logic         pop,
  b64enc_out_if.source chars
);

  group_t     cur;
  logic       busy;
  logic [1:0] idx;
  logic       advance;
  logic [5:0] sextet;
  logic [6:0] char_next;
  logic       last_next;

  assign advance = !chars.valid || chars.ready;
  // load the next group as soon as the current one sends its final beat
  assign pop     = head_valid && (!busy || (advance && idx == 2'd3));

  always_comb begin
    unique case (idx)
      2'd0: sextet = cur.b0[7:2];
      2'd1: sextet = {cur.b0[1:0], cur.b1[7:4]};
      2'd2: sextet = {cur.b1[3:0], cur.b2[7:6]};
      2'd3: sextet = cur.b2[5:0];
    endcase
    char_next = ({1'b0, idx} < cur.nchars) ? sextet_char(sextet) : PAD_CHAR;
    last_next = cur.last && (idx == 2'd3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (pop) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (advance && busy) begin
      idx <= idx + 2'd1;
      if (idx == 2'd3) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_group;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chars.valid <= 1'b0;
    end else if (advance) begin
      chars.valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && busy) begin
      chars.out_char <= char_next;
      chars.out_last <= last_next;
    end
  end

endmodule

`default_nettype wire

@@ src/base64_stream_encoder.sv @@
// ============================================================================
// base64_stream_encoder: byte stream to base64 characters
// Standard alphabet with '=' padding, one character per output beat.
// ============================================================================
// Usage:
//   bytes : one raw byte per beat (in_byte), in_last on the final byte.
//   chars : one ASCII character per beat (out_char), out_last on the final
//           character of the message.
//   Every three bytes give four characters; a last byte that closes a
//   partial group gives two or three characters and then "==" or "=".
//   The first character of a group passes through the group queue, the
//   emitter's group register and the output register.
//   Throughput: the emitter sends one character per cycle while the receiver
//   is ready, so a long message is paced by the characters. The gatherer
//   takes a byte every cycle until the two-entry group queue fills.
//   Reset clears the held count, the queue and the output stage.
//   When the receiver stalls, the output beat holds; the gatherer keeps
//   taking bytes until the queue is full, then drops ready.
// ============================================================================
`default_nettype none

module base64_stream_encoder
  import b64enc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  b64enc_in_if.sink    bytes,
  b64enc_out_if.source chars
);

  logic   push;
  group_t push_group;
  logic   queue_full;
  logic   head_valid;
  group_t head_group;
  logic   pop;

  b64enc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .bytes      (bytes),
    .queue_full (queue_full),
    .push       (push),
    .push_group (push_group)
  );

  b64enc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_group (push_group),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_group (head_group),
    .pop        (pop)
  );

  b64enc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_group (head_group),
    .pop        (pop),
    .chars      (chars)
  );

endmodule

`default_nettype wire

@@ sim/base64_stream_encoder_test.sv @@
`timescale 1ns / 1ps
// ============================================================================
// base64_stream_encoder_test: self-checking bench for the base64 encoder
// Drives byte messages through the valid/ready input channel and compares
// every character beat on the output channel against a bit-exact predictor
// of the RFC 4648 encoding with '=' padding. Random gaps on both sides, and
// one long receiver hold-off to back the block up into its input.
// ============================================================================

module base64_stream_encoder_test;
  import b64enc_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 12;
  localparam int QUIET_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_ITEMS  = 80;
  localparam int PRESSURE_LEN = 30;

  localparam string B64_ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } char_beat_t;

  // Predicts the characters each accepted byte releases and holds them
  // in order until the output beats arrive.
  class b64_char_board;
    logic [7:0]  held [2];
    int unsigned held_cnt = 0;
    char_beat_t  due_chars [$];
    int unsigned errors = 0;

    task flag_error(string msg);
      errors++;
      $display("ERROR @%0t: %s", $time, msg);
    endtask

    function void take_byte(logic [7:0] b, logic l);
      logic [7:0] g0, g1, g2;
      logic [5:0] sx [4];
      int unsigned nchars;
      byte        c;
      char_beat_t beat;
      if (held_cnt == 2) begin
        g0 = held[0];
        g1 = held[1];
        g2 = b;
        nchars = 4;
      end else begin
        held[held_cnt] = b;
        held_cnt++;
        if (!l) return;
        g0 = held[0];
        g1 = (held_cnt == 2) ? held[1] : 8'h00;
        g2 = 8'h00;
        nchars = held_cnt + 1;
      end
      sx[0] = g0[7:2];
      sx[1] = {g0[1:0], g1[7:4]};
      sx[2] = {g1[3:0], g2[7:6]};
      sx[3] = g2[5:0];
      for (int k = 0; k < 4; k++) begin
        c = B64_ALPHABET[sx[k]];
        beat.ch   = (k < nchars) ? c[6:0] : PAD_CHAR;
        beat.last = l && (k == 3);
        due_chars.push_back(beat);
      end
      held_cnt = 0;
    endfunction

    task match_char(logic [6:0] ch, logic last);
      char_beat_t want;
      if (due_chars.size() == 0) begin
        flag_error($sformatf("unexpected char 0x%02h last=%0b", ch, last));
        return;
      end
      want = due_chars.pop_front();
      if (ch !== want.ch)
        flag_error($sformatf("char 0x%02h, want 0x%02h", ch, want.ch));
      if (last !== want.last)
        flag_error($sformatf("last %0b, want %0b (char 0x%02h)", last, want.last, want.ch));
    endtask
  endclass

  logic clk;
  logic rst;

  b64enc_in_if  bytes_if ();
  b64enc_out_if chars_if ();

  base64_stream_encoder dut (
    .clk   (clk),
    .rst   (rst),
    .bytes (bytes_if),
    .chars (chars_if)
  );

  b64_char_board sb;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left      = 0;
  int unsigned items_sent     = 0;
  int unsigned quiet_cycles   = 0;

  // {last, byte}: single bytes at both extremes, a pair, a zero group, a full
  // group followed by a lone last byte, the "++++" pattern, and a 5-byte tail
  logic [8:0] dir_beats [19] = '{
    9'h100, 9'h1FF,
    9'h0FF, 9'h100,
    9'h000, 9'h000, 9'h100,
    9'h0FF, 9'h0FF, 9'h0FF, 9'h14D,
    9'h0FB, 9'h0EF, 9'h1BE,
    9'h001, 9'h002, 9'h003, 9'h004, 9'h105
  };

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_beat(logic [7:0] b, logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      bytes_if.valid <= 1'b0;
      @(negedge clk);
    end
    bytes_if.valid   <= 1'b1;
    bytes_if.in_byte <= b;
    bytes_if.in_last <= l;
    @(posedge clk);
    while (!bytes_if.ready) @(posedge clk);
    sb.take_byte(b, l);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      send_beat(8'($urandom_range(255)), i == len - 1);
  endtask

  function automatic int unsigned pick_length();
    if ($urandom_range(99) < 6) return $urandom_range(45, 20);
    return $urandom_range(9, 1);
  endfunction

  // Receiver: ready changes on the falling edge; a hold-off request wins.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        chars_if.ready <= 1'b0;
        hold_left--;
      end else begin
        chars_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && chars_if.valid && chars_if.ready)
      sb.match_char(chars_if.out_char, chars_if.out_last);
  end

  // Watchdog on cycles with no beat on either channel
  initial begin
    forever begin
      @(posedge clk);
      if ((bytes_if.valid && bytes_if.ready) || (chars_if.valid && chars_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TIMEOUT: no beat for %0d cycles", QUIET_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int unsigned phase_start;
    sb = new;
    rst              = 1'b1;
    bytes_if.valid   = 1'b0;
    bytes_if.in_byte = 8'h00;
    bytes_if.in_last = 1'b0;
    chars_if.ready   = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_beats[i]) send_beat(dir_beats[i][7:0], dir_beats[i][8]);

    // Back up the block: receiver holds off while bytes keep coming
    hold_left = HOLD_CYCLES;
    send_message(PRESSURE_LEN);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) send_message(pick_length());
    end

    bytes_if.valid <= 1'b0;
    recv_stall_pct = 0;
    while (sb.due_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.due_chars.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
